>>> src/pce_pkg.sv
// shared types, constants and the quarter-wave sine table for the chirp excitation unit
// no dependencies; imported by every module of the block
package pce_pkg;

   // time and command formats
   localparam int TIME_FRAC_BITS = 16;
   localparam int TIME_W         = 32;
   localparam int CMD_W          = 16;
   localparam int MODE_W         = 2;

   // chirp time never reaches 17 s, so it fits in five integer bits
   localparam int T_W   = TIME_FRAC_BITS + 5;
   localparam int SQ_W  = 2 * T_W;
   localparam int X_W   = SQ_W + 2;
   localparam int THR_W = T_W + 7;

   // phase in turns, q.2f
   localparam int PHASE_W = 2 * TIME_FRAC_BITS;

   // radix-16 long division of 4*t*t by 13 or 15
   localparam int DIG_W          = 4;
   localparam int DIV_STAGES     = 3;
   localparam int NDIG           = (X_W + DIG_W - 1) / DIG_W;
   localparam int DIG_PER_STAGE  = (NDIG + DIV_STAGES - 1) / DIV_STAGES;
   localparam int DIV_W          = DIG_W * DIG_PER_STAGE * DIV_STAGES;
   localparam int DEN_13         = 13;
   localparam int DEN_15         = 15;
   localparam int DIV_MUL_13     = 158;
   localparam int DIV_MUL_15     = 137;
   localparam int DIV_SHIFT      = 11;

   // sine table, power-of-two number of entries per full turn
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int IDX_W     = $clog2(SINE_TABLE_ENTRIES);
   localparam int QTR_W     = IDX_W - 2;
   localparam int ROM_DEPTH = (1 << QTR_W) + 1;
   localparam int ROM_AW    = QTR_W + 1;
   localparam int MAG_W     = 31;

   // amplitude and output scaling
   localparam int AMP_W       = 27;
   localparam int PROD_W      = AMP_W + MAG_W;
   localparam int ROUND_SHIFT = 47;
   localparam int EMAG_W      = PROD_W - ROUND_SHIFT + 1;

   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   localparam longint unsigned AMP_Q30_3P6 = 64'd36 * PI_Q30 / 64'd1800;
   localparam longint unsigned AMP_Q30_1P0 = 64'd10 * PI_Q30 / 64'd1800;
   localparam longint unsigned AMP_Q30_5P0 = 64'd50 * PI_Q30 / 64'd1800;
   localparam longint unsigned AMP_Q30_1P5 = 64'd15 * PI_Q30 / 64'd1800;

   // window bounds in q.f seconds
   localparam logic [TIME_W-1:0] SEC_1  = TIME_W'(1)  << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] SEC_7  = TIME_W'(7)  << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] SEC_16 = TIME_W'(16) << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] SEC_18 = TIME_W'(18) << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] SEC_24 = TIME_W'(24) << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] SEC_33 = TIME_W'(33) << TIME_FRAC_BITS;
   localparam logic [T_W-1:0]    T_11    = T_W'(11) << TIME_FRAC_BITS;
   localparam logic [T_W-1:0]    T_LIMIT = T_W'(17) << TIME_FRAC_BITS;
   localparam logic [THR_W-1:0]  THR_903 = THR_W'(903) << TIME_FRAC_BITS;
   localparam logic [THR_W-1:0]  CENTI   = THR_W'(100);

   typedef enum logic [MODE_W-1:0] {
      MODE_TWO_PAIR = 2'd0,
      MODE_L3_SINE  = 2'd1,
      MODE_L4_COS   = 2'd2,
      MODE_OFF      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      AMP_3P6 = 2'd0,
      AMP_1P0 = 2'd1,
      AMP_5P0 = 2'd2,
      AMP_1P5 = 2'd3
   } amp_type;

   typedef struct packed {
      logic [TIME_W-1:0]       now_time;
      logic signed [CMD_W-1:0] left3_in;
      logic signed [CMD_W-1:0] right3_in;
      logic signed [CMD_W-1:0] left4_in;
      logic signed [CMD_W-1:0] right4_in;
   } req_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] excite;
      logic                    excite_active;
      logic signed [CMD_W-1:0] left3_out;
      logic signed [CMD_W-1:0] right3_out;
      logic signed [CMD_W-1:0] left4_out;
      logic signed [CMD_W-1:0] right4_out;
   } rsp_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] left3;
      logic signed [CMD_W-1:0] right3;
      logic signed [CMD_W-1:0] left4;
      logic signed [CMD_W-1:0] right4;
   } cmd_type;

   // what an item carries down the pipe besides the arithmetic
   typedef struct packed {
      cmd_type        cmd;
      logic           active;
      logic           pair3;
      logic           pair4;
      logic           cosine;
      logic           den15;
      amp_type        amp_sel;
      logic [T_W-1:0] t;
   } carry_type;

   typedef struct packed {
      carry_type       c;
      logic [SQ_W-1:0] sq;
   } sq_item_type;

   typedef struct packed {
      carry_type          c;
      logic [PHASE_W-1:0] quot;
   } quot_item_type;

   typedef logic [MAG_W-1:0] sine_rom_type [ROM_DEPTH];

   // first quadrant of the sine, q30 magnitude, folded series to the x^11 term
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned h;
      int              j;
      for (j = 0; j < ROM_DEPTH; j++) begin
         r  = 64'(j) << (30 - QTR_W);
         x  = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         h  = ONE_Q30;
         h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd110;
         h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
         h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
         h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
         h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
         rom[j] = MAG_W'((x * h) >> 30);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

>>> src/pce_front.sv
// front end: mode register, entry time latch, elapsed time, window decode and t squared
// depends on pce_pkg
module pce_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [pce_pkg::MODE_W-1:0] csr_wr_data,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pce_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pce_pkg::sq_item_type out_data
);
   import pce_pkg::*;

   mode_type          mode_ff;
   logic [TIME_W-1:0] start_ff;
   logic              latched_ff;

   logic              va_ff, vb_ff, vc_ff;
   logic              rdy_a, rdy_b, rdy_c;

   logic [TIME_W-1:0] tau_in, tau_ff;
   mode_type          mode_a_ff;
   cmd_type           cmd_a_ff;

   carry_type         carry_b_in, carry_b_ff;
   carry_type         carry_c_in, carry_c_ff;
   logic [SQ_W-1:0]   sq_in, sq_ff;
   logic [THR_W-1:0]  centi_t;

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
      end else if (csr_wr_en) begin
         mode_ff <= mode_type'(csr_wr_data);
      end
   end

   // the first item sets the entry time, so its own tau is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= 1'b0;
         start_ff   <= '0;
      end else if (in_valid && rdy_a && !latched_ff) begin
         latched_ff <= 1'b1;
         start_ff   <= in_data.now_time;
      end
   end

   assign tau_in = latched_ff ? (in_data.now_time - start_ff) : '0;

   // window decode
   always_comb begin
      carry_b_in         = '0;
      carry_b_in.cmd     = cmd_a_ff;
      carry_b_in.amp_sel = AMP_1P0;
      unique case (mode_a_ff) inside
         MODE_L3_SINE, MODE_L4_COS: begin
            if (tau_ff > SEC_7 && tau_ff < SEC_24) begin
               carry_b_in.active = 1'b1;
               carry_b_in.den15  = 1'b1;
               carry_b_in.pair3  = (mode_a_ff == MODE_L3_SINE);
               carry_b_in.pair4  = (mode_a_ff == MODE_L4_COS);
               carry_b_in.cosine = (mode_a_ff == MODE_L4_COS);
               carry_b_in.t      = T_W'(tau_ff - SEC_7);
            end
         end
         MODE_TWO_PAIR: begin
            if (tau_ff > SEC_1 && tau_ff < SEC_16) begin
               carry_b_in.active = 1'b1;
               carry_b_in.pair3  = 1'b1;
               carry_b_in.t      = T_W'(tau_ff - SEC_1);
            end else if (tau_ff > SEC_18 && tau_ff < SEC_33) begin
               carry_b_in.active = 1'b1;
               carry_b_in.pair4  = 1'b1;
               carry_b_in.t      = T_W'(tau_ff - SEC_18);
            end
         end
         MODE_OFF: begin
         end
      endcase
   end

   // square of t and the amplitude step
   always_comb begin
      carry_c_in = carry_b_ff;
      sq_in      = SQ_W'(carry_b_ff.t) * SQ_W'(carry_b_ff.t);
      centi_t    = THR_W'(carry_b_ff.t) * CENTI;
      if (carry_b_ff.den15) begin
         carry_c_in.amp_sel = (centi_t < THR_903) ? AMP_3P6 : AMP_1P0;
      end else begin
         carry_c_in.amp_sel = (carry_b_ff.t < T_11) ? AMP_5P0 : AMP_1P5;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         tau_ff    <= tau_in;
         mode_a_ff <= mode_ff;
         cmd_a_ff  <= '{in_data.left3_in, in_data.right3_in,
                        in_data.left4_in, in_data.right4_in};
      end
      if (rdy_b) begin
         carry_b_ff <= carry_b_in;
      end
      if (rdy_c) begin
         carry_c_ff <= carry_c_in;
         sq_ff      <= sq_in;
      end
   end

   assign out_valid   = vc_ff;
   assign out_data.c  = carry_c_ff;
   assign out_data.sq = sq_ff;

   a_latch_on_accept: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> latched_ff)
      else $error("entry time not latched after an accepted item");

   a_latch_sticks: assert property (@(posedge clock) disable iff (reset)
      latched_ff |=> latched_ff)
      else $error("entry time latch dropped");

   a_t_in_window: assert property (@(posedge clock) disable iff (reset)
      vb_ff && carry_b_ff.active |-> carry_b_ff.t < T_LIMIT)
      else $error("chirp time beyond any window");

endmodule

>>> src/pce_divider.sv
// pipelined radix-16 division of 4*t*t by 13 or 15, four digits per stage
// depends on pce_pkg
module pce_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pce_pkg::sq_item_type   in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pce_pkg::quot_item_type out_data
);
   import pce_pkg::*;

   logic                  valid_ff [DIV_STAGES];
   logic [DIV_W-1:0]      work_ff  [DIV_STAGES];
   logic [DIG_W-1:0]      rem_ff   [DIV_STAGES];
   carry_type             carry_ff [DIV_STAGES];
   logic [DIV_STAGES:0]   rdy;

   // one quotient digit: reciprocal multiply, exact for these dividends
   function automatic logic [2*DIG_W-1:0] div_digit(input logic [2*DIG_W-1:0] v,
                                                    input logic den15);
      logic [15:0]          p;
      logic [DIG_W-1:0]     q;
      logic [2*DIG_W-1:0]   r;
      p = 16'(v) * (den15 ? 16'(DIV_MUL_15) : 16'(DIV_MUL_13));
      q = p[DIV_SHIFT +: DIG_W];
      r = v - 8'(q) * (den15 ? 8'(DEN_15) : 8'(DEN_13));
      return {q, r[DIG_W-1:0]};
   endfunction

   always_comb begin
      rdy[DIV_STAGES] = out_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign in_ready = rdy[0];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic             src_valid;
      logic [DIV_W-1:0] src_work;
      logic [DIG_W-1:0] src_rem;
      carry_type        src_carry;
      logic [DIV_W-1:0] work_in;
      logic [DIG_W-1:0] rem_in;
      logic [2*DIG_W-1:0] qr;

      if (k == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_work  = DIV_W'({in_data.sq, 2'b00});
         assign src_rem   = '0;
         assign src_carry = in_data.c;
      end else begin : g_body
         assign src_valid = valid_ff[k-1];
         assign src_work  = work_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_carry = carry_ff[k-1];
      end

      // dividend digits leave at the top while quotient digits enter at the bottom
      always_comb begin
         work_in = src_work;
         rem_in  = src_rem;
         qr      = '0;
         for (int d = 0; d < DIG_PER_STAGE; d++) begin
            qr      = div_digit({rem_in, work_in[DIV_W-1 -: DIG_W]}, src_carry.den15);
            work_in = {work_in[DIV_W-DIG_W-1:0], qr[2*DIG_W-1:DIG_W]};
            rem_in  = qr[DIG_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            work_ff[k]  <= work_in;
            rem_ff[k]   <= rem_in;
            carry_ff[k] <= src_carry;
         end
      end
   end

   assign out_valid     = valid_ff[DIV_STAGES-1];
   assign out_data.c    = carry_ff[DIV_STAGES-1];
   assign out_data.quot = work_ff[DIV_STAGES-1][PHASE_W-1:0];

   a_quot_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STAGES-1] && !out_ready |=>
         valid_ff[DIV_STAGES-1] && $stable(work_ff[DIV_STAGES-1]))
      else $error("quotient lost while the next stage stalls");

endmodule

>>> src/pce_sine.sv
// phase, table lookup, amplitude scaling and saturating adds onto the surface commands
// depends on pce_pkg
module pce_sine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pce_pkg::quot_item_type in_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pce_pkg::rsp_type       rsp_data
);
   import pce_pkg::*;

   localparam logic [ROM_AW-1:0] QTR_SPAN   = ROM_AW'(1) << QTR_W;
   localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W+1)'(1) << (ROUND_SHIFT - 1);

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                rdy1, rdy2, rdy3, rdy4;

   logic [PHASE_W-1:0]  t_shift;
   logic [PHASE_W-1:0]  phase;
   logic [IDX_W-1:0]    idx;
   logic [1:0]          quad;
   logic [QTR_W-1:0]    low;
   logic [ROM_AW-1:0]   j_in, j1_ff;
   logic                neg1_ff, neg2_ff, neg3_ff;
   carry_type           c1_ff, c2_ff, c3_ff;
   logic [MAG_W-1:0]    mag2_ff;
   logic [PROD_W-1:0]   prod_in, prod3_ff;
   logic [PROD_W:0]     rounded;
   logic [EMAG_W-1:0]   emag;
   logic signed [CMD_W-1:0] excite;
   logic signed [CMD_W-1:0] e3, e4;
   rsp_type             rsp_in, rsp_ff;

   function automatic logic [AMP_W-1:0] amp_value(input amp_type a);
      logic [AMP_W-1:0] v;
      case (a)
         AMP_3P6: v = AMP_W'(AMP_Q30_3P6);
         AMP_1P0: v = AMP_W'(AMP_Q30_1P0);
         AMP_5P0: v = AMP_W'(AMP_Q30_5P0);
         default: v = AMP_W'(AMP_Q30_1P5);
      endcase
      return v;
   endfunction

   function automatic logic signed [CMD_W-1:0] sat_add(input logic signed [CMD_W-1:0] a,
                                                       input logic signed [CMD_W-1:0] b);
      logic signed [CMD_W:0] s;
      logic signed [CMD_W-1:0] r;
      s = {a[CMD_W-1], a} + {b[CMD_W-1], b};
      if (s[CMD_W] != s[CMD_W-1]) begin
         r = s[CMD_W] ? {1'b1, {(CMD_W-1){1'b0}}} : {1'b0, {(CMD_W-1){1'b1}}};
      end else begin
         r = s[CMD_W-1:0];
      end
      return r;
   endfunction

   assign rdy4     = !v4_ff || rsp_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // phase in turns, then fold the top bits onto the first quadrant
   always_comb begin
      t_shift = PHASE_W'({in_data.c.t, {(TIME_FRAC_BITS-1){1'b0}}});
      phase   = in_data.quot + t_shift;
      idx     = phase[PHASE_W-1 -: IDX_W];
      quad    = idx[IDX_W-1 -: 2] + {1'b0, in_data.c.cosine};
      low     = idx[QTR_W-1:0];
      j_in    = quad[0] ? (QTR_SPAN - ROM_AW'(low)) : ROM_AW'(low);
   end

   assign prod_in = PROD_W'(amp_value(c2_ff.amp_sel)) * PROD_W'(mag2_ff);

   // round half up, apply sign, zero outside a window
   always_comb begin
      rounded = (PROD_W+1)'(prod3_ff) + ROUND_HALF;
      emag    = rounded[PROD_W:ROUND_SHIFT];
      if (!c3_ff.active) begin
         excite = '0;
      end else if (neg3_ff) begin
         excite = -$signed({{(CMD_W-EMAG_W){1'b0}}, emag});
      end else begin
         excite = $signed({{(CMD_W-EMAG_W){1'b0}}, emag});
      end
      e3 = c3_ff.pair3 ? excite : '0;
      e4 = c3_ff.pair4 ? excite : '0;
      rsp_in.excite        = excite;
      rsp_in.excite_active = c3_ff.active;
      rsp_in.left3_out     = sat_add(c3_ff.cmd.left3, e3);
      rsp_in.right3_out    = sat_add(c3_ff.cmd.right3, e3);
      rsp_in.left4_out     = sat_add(c3_ff.cmd.left4, e4);
      rsp_in.right4_out    = sat_add(c3_ff.cmd.right4, e4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         j1_ff   <= j_in;
         neg1_ff <= quad[1];
         c1_ff   <= in_data.c;
      end
      if (rdy2) begin
         mag2_ff <= SINE_ROM[j1_ff];
         neg2_ff <= neg1_ff;
         c2_ff   <= c1_ff;
      end
      if (rdy3) begin
         prod3_ff <= prod_in;
         neg3_ff  <= neg2_ff;
         c3_ff    <= c2_ff;
      end
      if (rdy4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp_ff;

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.excite_active |-> rsp_data.excite == '0)
      else $error("excitation present outside a window");

   a_one_pair: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> !(c3_ff.pair3 && c3_ff.pair4))
      else $error("both surface pairs driven at once");

endmodule

>>> src/pitch_chirp_excitation_unit.sv
// Pitch chirp excitation unit.
// Input channel req_*: one frame per item, time plus four surface commands.
// Output channel rsp_*: one result item per frame, in order: the excitation,
// its active flag and the four commands with the excitation added and saturated.
// csr_wr_en / csr_wr_data write the two-bit mode at once; write it only while
// no item is in flight.
// Path: a frame passes three front stages, three divider stages and four sine
// stages before its result is offered.
// Throughput: one item per cycle; every stage has its own valid bit and the
// ready chain lets bubbles close up, so a stalled rsp_ready only backs up
// into req_ready once the whole pipe is full.
// Reset clears all valid bits and the entry-time latch and sets the mode to off;
// the first frame after reset sets the entry time.
// Depends on pce_pkg, pce_front, pce_divider and pce_sine.
module pitch_chirp_excitation_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [pce_pkg::MODE_W-1:0] csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pce_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pce_pkg::rsp_type           rsp_data
);
   import pce_pkg::*;

   logic          sq_valid, sq_ready;
   sq_item_type   sq_item;
   logic          quot_valid, quot_ready;
   quot_item_type quot_item;

   pce_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data),
      .out_valid   (sq_valid),
      .out_ready   (sq_ready),
      .out_data    (sq_item)
   );

   pce_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_item),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_item)
   );

   pce_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (quot_valid),
      .in_ready  (quot_ready),
      .in_data   (quot_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
